// ===== rtl/ptrd_pkg.sv =====
// shared constants, types and helpers for the planar texture row deinterleaver
// no dependencies; compiled first
`default_nettype none

package ptrd_pkg;

    // widest texture row; a power of two
    localparam int MAX_WIDTH       = 2048;
    localparam int MIN_LEVEL_WIDTH = 4;

    localparam int MAX_LOG2 = $clog2(MAX_WIDTH);
    localparam int MIN_LOG2 = $clog2(MIN_LEVEL_WIDTH);

    // row store: three colour planes of MAX_WIDTH bytes
    localparam int KW          = MAX_LOG2;
    localparam int STORE_AW    = KW + 2;
    localparam int STORE_DEPTH = 3 * MAX_WIDTH;

    // row position covers 3w + w/8 + w, row count covers w
    localparam int POS_W = $clog2(5 * MAX_WIDTH);
    localparam int RC_W  = $clog2(MAX_WIDTH + 1);

    // field widths
    localparam int BYTE_W  = 8;
    localparam int CH_W    = 2;
    localparam int LOG2_W  = 4;
    localparam int LEVEL_W = 4;
    localparam int MODE_W  = 3;
    localparam int BLEN_W  = 32;
    localparam int LCNT_W  = 3;
    localparam int PIX_W   = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(MAX_LOG2 - MIN_LOG2);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_LOG2    = 2'd0,
        CFG_CHANNEL_MODE = 2'd1,
        CFG_MIP_ENABLE   = 2'd2,
        CFG_COMPRESSED   = 2'd3
    } cfg_index_t;

    // channel mode codes
    localparam logic [MODE_W-1:0] MODE_RGB   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MASK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ALPHA = 3'd5;

    // channel codes
    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;
    localparam logic [CH_W-1:0] CH_ALPHA = 2'd3;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic take;     // input word accepted this cycle
        logic rd_cur;   // read store at the cursor
        logic step;     // load result register and advance cursor
        logic rd_next;  // read store at the advanced cursor
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic has_results;      // word at the input causes results
        logic needs_read;       // its results come from the row store
        logic out_free;         // result register can take a word
        logic is_last;          // cursor sits on the last result
        logic next_needs_read;  // advanced cursor is a store channel
    } dp_status_t;

    // clamp a size to the supported range of levels
    function automatic logic [LOG2_W-1:0] clamp_log2(input logic [LOG2_W-1:0] s);
        logic [LOG2_W-1:0] r;
        r = s;
        if (s < LOG2_W'(MIN_LOG2))
            r = LOG2_W'(MIN_LOG2);
        else if (s > LOG2_W'(MAX_LOG2))
            r = LOG2_W'(MAX_LOG2);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ptrd_if.sv =====
// valid/ready channel interfaces for input bytes and result words
// uses ptrd_pkg for field widths
`default_nettype none

interface ptrd_in_if;
    import ptrd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface ptrd_out_if;
    import ptrd_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  pixel_byte;
    logic [CH_W-1:0]    channel;
    logic               run_last;
    logic               level_end;
    logic               image_end;
    logic [LEVEL_W-1:0] level_index;

    modport source (output valid, output pixel_byte, output channel, output run_last,
                    output level_end, output image_end, output level_index, input ready);
    modport sink   (input valid, input pixel_byte, input channel, input run_last,
                    input level_end, input image_end, input level_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/ptrd_ram.sv =====
// generic single write, single read RAM with registered read data
// no dependencies
`default_nettype none

module ptrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/ptrd_ctrl.sv =====
// controller: sequences accept, store read and one result word per cycle while the output is free
// uses ptrd_pkg for state and command types
`default_nettype none

module ptrd_ctrl
    import ptrd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && status.has_results)
                    state_next = status.needs_read ? S_ISSUE : S_EMIT;
            end
            S_ISSUE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free && status.is_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            S_ISSUE:
            begin
                cmd.rd_cur = 1'b1;
            end
            S_EMIT:
            begin
                cmd.step    = status.out_free;
                cmd.rd_next = status.out_free && !status.is_last && status.next_needs_read;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ptrd_datapath.sv =====
// datapath: config registers, row and level counters, row store, result cursor
// uses ptrd_pkg and ptrd_ram
`default_nettype none

module ptrd_datapath
    import ptrd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [BYTE_W-1:0]     in_byte,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [BYTE_W-1:0]          out_pixel_byte,
    output logic [CH_W-1:0]            out_channel,
    output logic                       out_run_last,
    output logic                       out_level_end,
    output logic                       out_image_end,
    output logic [LEVEL_W-1:0]         out_level_index
);

    // configuration
    logic [LOG2_W-1:0] size_reg, size_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              mip_reg, mip_next;
    logic              comp_reg, comp_next;
    logic              restart;

    // stream position
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [RC_W-1:0]    row_reg, row_next;
    logic [LOG2_W-1:0]  lw_reg, lw_next;
    logic [LEVEL_W-1:0] lvl_reg, lvl_next;
    logic [BLEN_W-1:0]  blen_reg, blen_next;
    logic [LCNT_W-1:0]  lcnt_reg, lcnt_next;
    logic               fin_reg, fin_next;

    // current job and cursor
    logic [KW-1:0]      job_base_reg;
    logic [PIX_W-1:0]   job_last_pix_reg;
    logic               job_alpha_reg;
    logic               job_mask_reg;
    logic               job_pass_reg;
    logic [BYTE_W-1:0]  job_byte_reg;
    logic               job_level_end_reg;
    logic               job_image_end_reg;
    logic [LEVEL_W-1:0] job_level_reg;
    logic [CH_W-1:0]    cur_ch_reg, cur_ch_next;
    logic [PIX_W-1:0]   cur_pix_reg, cur_pix_next;

    // result register
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [CH_W-1:0]    out_ch_reg;
    logic               out_last_reg;
    logic               out_lend_reg;
    logic               out_iend_reg;
    logic [LEVEL_W-1:0] out_lvl_reg;

    // level geometry
    logic               mode4, mode5, last_level;
    logic [POS_W-1:0]   w, kmask, w3, mlen, wm, rsz;
    logic [POS_W-1:0]   pos_inc, p_shift, mask_off, mask_off_sh, alpha_off;
    logic [RC_W-1:0]    row_inc;
    logic               in_plane, in_mask, row_end, level_end_u;
    logic [1:0]         plane;
    logic [KW-1:0]      k_plane, k_mask, k_alpha;
    logic               uncomp_has;

    // compressed length
    logic [BLEN_W-1:0]  blen_new;
    logic               zero_block, pass_done, level_end_evt;

    // store
    logic                store_we, store_re;
    logic [STORE_AW-1:0] store_waddr, store_raddr;
    logic [BYTE_W-1:0]   store_rdata;
    logic [CH_W-1:0]     sel_ch;
    logic [PIX_W-1:0]    sel_pix;

    // result selection
    logic [CH_W-1:0]    last_ch;
    logic               is_last;
    logic [BYTE_W-1:0]  alpha_byte, res_byte;
    logic [CH_W-1:0]    res_ch;

    // geometry of the current level
    always_comb
    begin
        mode4       = (mode_reg == MODE_MASK);
        mode5       = (mode_reg >= MODE_ALPHA);
        last_level  = !mip_reg || (lw_reg <= LOG2_W'(MIN_LOG2));
        w           = POS_W'(1) << lw_reg;
        kmask       = w - POS_W'(1);
        w3          = (w << 1) + w;
        mlen        = (lw_reg < LOG2_W'(3)) ? POS_W'(1) : (w >> 3);
        wm          = w3 + mlen;
        rsz         = w3 + ((mode4 || mode5) ? mlen : '0) + (mode5 ? w : '0);
        pos_inc     = pos_reg + POS_W'(1);
        row_inc     = row_reg + RC_W'(1);
        in_plane    = (pos_reg < w3);
        in_mask     = !in_plane && (pos_reg < wm);
        p_shift     = pos_reg >> lw_reg;
        plane       = p_shift[1:0];
        k_plane     = KW'(pos_reg & kmask);
        mask_off    = pos_reg - w3;
        mask_off_sh = mask_off << 3;
        k_mask      = KW'(mask_off_sh);
        alpha_off   = pos_reg - wm;
        k_alpha     = KW'(alpha_off);
        row_end     = (pos_inc >= rsz);
        level_end_u = (pos_inc == rsz) && (row_inc == RC_W'(w));
        uncomp_has  = (in_plane && !mode4 && !mode5 && (plane == 2'd2))
                    || (in_mask && mode4)
                    || (!in_plane && !in_mask);
    end

    // compressed length assembly
    always_comb
    begin
        blen_new      = blen_reg | (BLEN_W'(in_byte) << {lcnt_reg[1:0], 3'b000});
        zero_block    = (lcnt_reg == LCNT_W'(3)) && (blen_new == '0);
        pass_done     = (blen_reg == BLEN_W'(1));
        if (comp_reg)
            level_end_evt = lcnt_reg[2] ? pass_done : zero_block;
        else
            level_end_evt = level_end_u;
    end

    // configuration writes
    always_comb
    begin
        size_next = size_reg;
        mode_next = mode_reg;
        mip_next  = mip_reg;
        comp_next = comp_reg;
        restart   = 1'b0;
        if (cfg_we)
        begin
            restart = 1'b1;
            unique case (cfg_index_t'(cfg_index))
                CFG_SIZE_LOG2:    size_next = cfg_data[LOG2_W-1:0];
                CFG_CHANNEL_MODE: mode_next = cfg_data[MODE_W-1:0];
                CFG_MIP_ENABLE:   mip_next  = cfg_data[0];
                CFG_COMPRESSED:   comp_next = cfg_data[0];
                default:          restart   = 1'b0;
            endcase
        end
    end

    // stream position update
    always_comb
    begin
        pos_next  = pos_reg;
        row_next  = row_reg;
        lw_next   = lw_reg;
        lvl_next  = lvl_reg;
        blen_next = blen_reg;
        lcnt_next = lcnt_reg;
        fin_next  = fin_reg;
        if (restart)
        begin
            pos_next  = '0;
            row_next  = '0;
            lw_next   = clamp_log2(size_next);
            lvl_next  = '0;
            blen_next = '0;
            lcnt_next = '0;
            fin_next  = 1'b0;
        end
        else if (cmd.take && !fin_reg)
        begin
            if (level_end_evt)
            begin
                pos_next  = '0;
                row_next  = '0;
                blen_next = '0;
                lcnt_next = '0;
                if (last_level)
                    fin_next = 1'b1;
                else
                begin
                    lw_next  = lw_reg - LOG2_W'(1);
                    lvl_next = lvl_reg + LEVEL_W'(1);
                end
            end
            else if (comp_reg)
            begin
                if (!lcnt_reg[2])
                begin
                    blen_next = blen_new;
                    lcnt_next = lcnt_reg + LCNT_W'(1);
                end
                else
                    blen_next = blen_reg - BLEN_W'(1);
            end
            else if (row_end)
            begin
                pos_next = '0;
                row_next = row_inc;
            end
            else
                pos_next = pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= LOG2_W'(MIN_LOG2);
            mode_reg <= MODE_RGB;
            mip_reg  <= 1'b0;
            comp_reg <= 1'b0;
            pos_reg  <= '0;
            row_reg  <= '0;
            lw_reg   <= LOG2_W'(MIN_LOG2);
            lvl_reg  <= '0;
            blen_reg <= '0;
            lcnt_reg <= '0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            size_reg <= size_next;
            mode_reg <= mode_next;
            mip_reg  <= mip_next;
            comp_reg <= comp_next;
            pos_reg  <= pos_next;
            row_reg  <= row_next;
            lw_reg   <= lw_next;
            lvl_reg  <= lvl_next;
            blen_reg <= blen_next;
            lcnt_reg <= lcnt_next;
            fin_reg  <= fin_next;
        end
    end

    // job capture on accept
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            job_base_reg      <= in_plane ? k_plane : (in_mask ? k_mask : k_alpha);
            job_last_pix_reg  <= in_mask ? ((lw_reg < LOG2_W'(3)) ? kmask[PIX_W-1:0]
                                                                   : PIX_W'(7))
                                         : '0;
            job_alpha_reg     <= !in_plane;
            job_mask_reg      <= in_mask;
            job_pass_reg      <= comp_reg;
            job_byte_reg      <= in_byte;
            job_level_end_reg <= level_end_evt;
            job_image_end_reg <= level_end_evt && last_level;
            job_level_reg     <= lvl_reg;
        end
    end

    // cursor over the results of the job
    always_comb
    begin
        last_ch = job_alpha_reg ? CH_ALPHA : CH_BLUE;
        if (cur_ch_reg == last_ch)
        begin
            cur_ch_next  = CH_RED;
            cur_pix_next = cur_pix_reg + PIX_W'(1);
        end
        else
        begin
            cur_ch_next  = cur_ch_reg + CH_W'(1);
            cur_pix_next = cur_pix_reg;
        end
        is_last = job_pass_reg || ((cur_pix_reg == job_last_pix_reg) && (cur_ch_reg == last_ch));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_ch_reg  <= CH_RED;
            cur_pix_reg <= '0;
        end
        else if (cmd.take)
        begin
            cur_ch_reg  <= CH_RED;
            cur_pix_reg <= '0;
        end
        else if (cmd.step)
        begin
            cur_ch_reg  <= cur_ch_next;
            cur_pix_reg <= cur_pix_next;
        end
    end

    // row store: colour planes written on accept, read one channel per cycle while the output is free
    always_comb
    begin
        store_we    = cmd.take && !fin_reg && !comp_reg && in_plane;
        store_waddr = {plane, k_plane};
        store_re    = cmd.rd_cur || cmd.rd_next;
        sel_ch      = cmd.rd_cur ? cur_ch_reg  : cur_ch_next;
        sel_pix     = cmd.rd_cur ? cur_pix_reg : cur_pix_next;
        store_raddr = {sel_ch, job_base_reg + KW'(sel_pix)};
    end

    ptrd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (in_byte),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // result byte selection
    always_comb
    begin
        alpha_byte = job_mask_reg ? {BYTE_W{job_byte_reg[PIX_W'(7) - cur_pix_reg]}}
                                  : job_byte_reg;
        if (job_pass_reg)
        begin
            res_byte = job_byte_reg;
            res_ch   = CH_RED;
        end
        else if (cur_ch_reg == CH_ALPHA)
        begin
            res_byte = alpha_byte;
            res_ch   = CH_ALPHA;
        end
        else
        begin
            res_byte = store_rdata;
            res_ch   = cur_ch_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            out_byte_reg <= res_byte;
            out_ch_reg   <= res_ch;
            out_last_reg <= is_last;
            out_lend_reg <= is_last && job_level_end_reg;
            out_iend_reg <= is_last && job_image_end_reg;
            out_lvl_reg  <= job_level_reg;
        end
    end

    // status to controller
    always_comb
    begin
        status.has_results     = !fin_reg && (comp_reg ? lcnt_reg[2] : uncomp_has);
        status.needs_read      = !comp_reg;
        status.out_free        = !out_valid_reg || out_ready;
        status.is_last         = is_last;
        status.next_needs_read = (cur_ch_next != CH_ALPHA);
    end

    assign out_valid       = out_valid_reg;
    assign out_pixel_byte  = out_byte_reg;
    assign out_channel     = out_ch_reg;
    assign out_run_last    = out_last_reg;
    assign out_level_end   = out_lend_reg;
    assign out_image_end   = out_iend_reg;
    assign out_level_index = out_lvl_reg;

endmodule

`default_nettype wire

// ===== rtl/planar_texture_row_deinterleaver_top.sv =====
// top level of the planar texture row deinterleaver
// uses ptrd_pkg, ptrd_if, ptrd_ctrl and ptrd_datapath
`default_nettype none

// Turns the planar pixel stream of a square texture (R, G and B planes per row, then an
// optional mask or alpha plane, mip levels down to width 4, or length-prefixed compressed
// levels passed through) into interleaved RGB or RGBA bytes. A byte that causes no result
// needs only the accept step. For a byte that causes N results (1 to 32) the block accepts
// it, makes the first read through the single read port of the row store, then gives one
// result word per cycle while the output does not stall, paced by that read port and the
// one result register. A compressed data byte skips the store read. The row store is
// written before it is read in every row and needs no clearing after reset. Writing any
// configuration register restarts the stream at level 0, row 0; write configuration only
// while the block is idle.
module planar_texture_row_deinterleaver_top
    import ptrd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    ptrd_in_if.sink                    in_chan,
    ptrd_out_if.source                 out_chan
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       in_ready;

    // controller
    ptrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_chan.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    ptrd_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_byte         (in_chan.data_byte),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_chan.valid),
        .out_ready       (out_chan.ready),
        .out_pixel_byte  (out_chan.pixel_byte),
        .out_channel     (out_chan.channel),
        .out_run_last    (out_chan.run_last),
        .out_level_end   (out_chan.level_end),
        .out_image_end   (out_chan.image_end),
        .out_level_index (out_chan.level_index)
    );

    assign in_chan.ready = in_ready;

endmodule

`default_nettype wire

// ===== rtl/ptrd_checker.sv =====
// port-level checks on the result channel of the deinterleaver, bound to the top level
// uses ptrd_pkg; attaches to planar_texture_row_deinterleaver_top
`default_nettype none

module ptrd_checker
    import ptrd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [BYTE_W-1:0]  pixel_byte,
    input wire logic [CH_W-1:0]    channel,
    input wire logic               run_last,
    input wire logic               level_end,
    input wire logic               image_end,
    input wire logic [LEVEL_W-1:0] level_index
);

    // a stalled word stays and holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({pixel_byte, channel, run_last, level_end, image_end, level_index}))
    else $error("stalled result word changed");

    // a level only ends on the last word of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && level_end |-> run_last)
    else $error("level end off a run boundary");

    // the image ends only where a level ends
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_end |-> level_end)
    else $error("image end without level end");

    // level index stays within the mip chain
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> level_index <= LEVEL_MAX)
    else $error("level index beyond last level");

endmodule

bind planar_texture_row_deinterleaver_top ptrd_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .pixel_byte  (out_chan.pixel_byte),
    .channel     (out_chan.channel),
    .run_last    (out_chan.run_last),
    .level_end   (out_chan.level_end),
    .image_end   (out_chan.image_end),
    .level_index (out_chan.level_index)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for planar_texture_row_deinterleaver_top
// depends on rtl/ptrd_pkg.sv, rtl/ptrd_if.sv and the top level with its submodules
`timescale 1ns / 100ps

module testbench;
    import ptrd_pkg::*;

    localparam int TAIL_CYCLES = 48;
    localparam int RANDOM_WORDS = 12;

    // one result word as the block should present it
    typedef struct packed {
        logic [BYTE_W-1:0]  pixel_byte;
        logic [CH_W-1:0]    channel;
        logic               run_last;
        logic               level_end;
        logic               image_end;
        logic [LEVEL_W-1:0] level_index;
    } pixel_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ptrd_in_if  in_chan();
    ptrd_out_if out_chan();

    planar_texture_row_deinterleaver_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_chan   (in_chan),
        .out_chan  (out_chan)
    );

    // predicted result words, oldest first
    pixel_word_t pending_words[$];
    pixel_word_t step_words[$];

    // predictor copy of the block's state and registers
    logic [BYTE_W-1:0] row_store [STORE_DEPTH];
    int unsigned       row_pos;
    int unsigned       row_cnt;
    int unsigned       lvl_log2;
    int unsigned       lvl_num;
    logic [31:0]       blen;
    int unsigned       len_bytes;
    bit                image_done;
    logic [3:0]        reg_size;
    logic [2:0]        reg_mode;
    bit                reg_mip;
    bit                reg_comp;

    int  failures = 0;
    int  words_sent = 0;
    bit  calm = 1'b0;
    int  stall_left = 0;

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void restart_stream();
        lvl_log2 = reg_size;
        if (lvl_log2 < MIN_LOG2)
            lvl_log2 = MIN_LOG2;
        if (lvl_log2 > MAX_LOG2)
            lvl_log2 = MAX_LOG2;
        lvl_num    = 0;
        row_pos    = 0;
        row_cnt    = 0;
        blen       = '0;
        len_bytes  = 0;
        image_done = 1'b0;
    endfunction

    function automatic void apply_register(input cfg_index_t idx, input logic [3:0] value);
        case (idx)
            CFG_SIZE_LOG2:    reg_size = value;
            CFG_CHANNEL_MODE: reg_mode = value[2:0];
            CFG_MIP_ENABLE:   reg_mip  = value[0];
            CFG_COMPRESSED:   reg_comp = value[0];
            default:          return;
        endcase
        restart_stream();
    endfunction

    function automatic logic [2:0] active_mode();
        if (reg_mode == MODE_MASK)
            return MODE_MASK;
        if (reg_mode >= MODE_ALPHA)
            return MODE_ALPHA;
        return MODE_RGB;
    endfunction

    function automatic bit on_last_level();
        return !reg_mip || lvl_log2 <= MIN_LOG2;
    endfunction

    // bytes in one row of a level of width 2^l
    function automatic int unsigned row_bytes(input int unsigned l);
        int unsigned w;
        int unsigned mask_len;
        w = 1 << l;
        mask_len = (w < 8) ? 1 : w / 8;
        return 3 * w + ((active_mode() != MODE_RGB) ? mask_len : 0)
                     + ((active_mode() == MODE_ALPHA) ? w : 0);
    endfunction

    // bytes of a whole uncompressed image from the current level on
    function automatic int unsigned image_bytes();
        int unsigned l;
        int unsigned total;
        l = lvl_log2;
        total = 0;
        forever
        begin
            total += (1 << l) * row_bytes(l);
            if (!reg_mip || l <= MIN_LOG2)
                break;
            l--;
        end
        return total;
    endfunction

    function automatic int unsigned level_count();
        return reg_mip ? lvl_log2 - MIN_LOG2 + 1 : 1;
    endfunction

    function automatic void finish_level();
        row_pos   = 0;
        row_cnt   = 0;
        blen      = '0;
        len_bytes = 0;
        if (on_last_level())
            image_done = 1'b1;
        else
        begin
            lvl_log2--;
            lvl_num = (lvl_num + 1) & 15;
        end
    endfunction

    // add one word at the end of the current burst
    function automatic void append_step(input pixel_word_t w);
        step_words = {step_words, w};
    endfunction

    function automatic void emit(input logic [7:0] value, input logic [CH_W-1:0] ch);
        pixel_word_t w;
        w.pixel_byte  = value;
        w.channel     = ch;
        w.run_last    = 1'b0;
        w.level_end   = 1'b0;
        w.image_end   = 1'b0;
        w.level_index = LEVEL_W'(lvl_num);
        append_step(w);
    endfunction

    function automatic void emit_pixel(input int unsigned k, input bit with_alpha,
                                       input logic [7:0] alpha);
        k &= MAX_WIDTH - 1;
        emit(row_store[k], CH_RED);
        emit(row_store[MAX_WIDTH + k], CH_GREEN);
        emit(row_store[2 * MAX_WIDTH + k], CH_BLUE);
        if (with_alpha)
            emit(alpha, CH_ALPHA);
    endfunction

    // mark the last word of this input's burst and queue the burst
    function automatic void close_burst(input bit lvl_done, input bit last_lvl);
        pixel_word_t tail;
        if (step_words.size() == 0)
            return;
        tail = step_words.pop_back();
        tail.run_last  = 1'b1;
        tail.level_end = lvl_done;
        tail.image_end = lvl_done && last_lvl;
        append_step(tail);
        pending_words = {pending_words, step_words};
        step_words.delete();
    endfunction

    function automatic void deinterleave_word(input logic [7:0] b);
        bit          last_lvl;
        bit          lvl_done;
        int unsigned w;
        int unsigned mask_len;
        int unsigned rsz;
        int unsigned p;
        int unsigned plane;
        int unsigned k;
        int unsigned base;
        int unsigned cnt;
        logic [2:0]  mode;

        if (image_done)
            return;
        last_lvl = on_last_level();
        step_words.delete();

        // length prefix, then pass-through bytes
        if (reg_comp)
        begin
            if (len_bytes < 4)
            begin
                blen |= 32'(b) << (8 * len_bytes);
                len_bytes++;
                if (len_bytes == 4 && blen == 0)
                    finish_level();
                return;
            end
            lvl_done = (blen == 1);
            emit(b, CH_RED);
            close_burst(lvl_done, last_lvl);
            blen--;
            if (lvl_done)
                finish_level();
            return;
        end

        w        = 1 << lvl_log2;
        mode     = active_mode();
        mask_len = (w < 8) ? 1 : w / 8;
        rsz      = row_bytes(lvl_log2);
        p        = row_pos;

        if (p < 3 * w)
        begin
            // colour planes go into the row store
            plane = p / w;
            k     = p % w;
            row_store[plane * MAX_WIDTH + (k & (MAX_WIDTH - 1))] = b;
            if (mode == MODE_RGB && plane == 2)
                emit_pixel(k, 1'b0, 8'h00);
        end
        else if (p < 3 * w + mask_len)
        begin
            // mask byte: one pixel per bit, msb first
            if (mode == MODE_MASK)
            begin
                base = 8 * (p - 3 * w);
                cnt  = (w < 8) ? w : 8;
                for (int j = 0; j < cnt; j++)
                    emit_pixel(base + j, 1'b1, b[7 - j] ? 8'hFF : 8'h00);
            end
        end
        else
            emit_pixel(p - 3 * w - mask_len, 1'b1, b);

        lvl_done = (p + 1 == rsz) && (row_cnt + 1 == w);
        close_burst(lvl_done, last_lvl);

        row_pos = p + 1;
        if (row_pos >= rsz)
        begin
            row_pos = 0;
            row_cnt++;
            if (row_cnt >= w)
                finish_level();
        end
    endfunction

    // ---------------------------------------------------------------- result check

    always @(posedge clk)
    begin : check_words
        pixel_word_t want;
        if (rst_n && out_chan.valid && out_chan.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: pixel_byte %0d channel %0d",
                       out_chan.pixel_byte, out_chan.channel);
                failures++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (out_chan.pixel_byte !== want.pixel_byte)
                begin
                    $error("pixel_byte: expected %0d, actual %0d",
                           want.pixel_byte, out_chan.pixel_byte);
                    failures++;
                end
                if (out_chan.channel !== want.channel)
                begin
                    $error("channel: expected %0d, actual %0d", want.channel, out_chan.channel);
                    failures++;
                end
                if (out_chan.run_last !== want.run_last)
                begin
                    $error("run_last: expected %0d, actual %0d",
                           want.run_last, out_chan.run_last);
                    failures++;
                end
                if (out_chan.level_end !== want.level_end)
                begin
                    $error("level_end: expected %0d, actual %0d",
                           want.level_end, out_chan.level_end);
                    failures++;
                end
                if (out_chan.image_end !== want.image_end)
                begin
                    $error("image_end: expected %0d, actual %0d",
                           want.image_end, out_chan.image_end);
                    failures++;
                end
                if (out_chan.level_index !== want.level_index)
                begin
                    $error("level_index: expected %0d, actual %0d",
                           want.level_index, out_chan.level_index);
                    failures++;
                end
            end
        end
    end

    // receiver stalls in random bursts
    always @(negedge clk)
    begin
        if (calm)
            out_chan.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_chan.ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            out_chan.ready <= 1'b0;
            stall_left = $urandom_range(1, 6) - 1;
        end
        else
            out_chan.ready <= 1'b1;
    end

    // ---------------------------------------------------------------- drivers

    // stop sending and wait until every predicted word has come out
    task automatic settle(input int tail);
        in_chan.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_words.size() != 0);
        repeat (tail) @(negedge clk);
    endtask

    task automatic send_word(input logic [7:0] value);
        if (!calm && $urandom_range(0, 59) == 0)
            settle(0);
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_chan.valid     <= 1'b1;
        in_chan.data_byte <= value;
        do
            @(posedge clk);
        while (!in_chan.ready);
        if (!image_done)
            words_sent++;
        deinterleave_word(value);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [3:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        apply_register(idx, value);
        @(negedge clk);
    endtask

    // write all four registers once the block has gone quiet; unused upper bits are random
    task automatic configure(input logic [3:0] size, input logic [2:0] mode,
                             input bit mip, input bit comp);
        settle(TAIL_CYCLES);
        write_reg(CFG_SIZE_LOG2, size);
        write_reg(CFG_CHANNEL_MODE, {1'($urandom_range(0, 1)), mode});
        write_reg(CFG_MIP_ENABLE, {3'($urandom_range(0, 7)), mip});
        write_reg(CFG_COMPRESSED, {3'($urandom_range(0, 7)), comp});
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_plain(input int unsigned count);
        repeat (count) send_word(rand_byte());
    endtask

    task automatic send_image();
        send_plain(image_bytes());
    endtask

    // one length-prefixed block per level
    task automatic send_compressed(input int unsigned max_len, input bit first_empty);
        logic [31:0] len;
        int unsigned levels;
        levels = level_count();
        for (int lvl = 0; lvl < levels; lvl++)
        begin
            if ((first_empty && lvl == 0) || $urandom_range(0, 5) == 0)
                len = 0;
            else
                len = $urandom_range(1, max_len);
            for (int i = 0; i < 4; i++)
                send_word(len[8 * i +: 8]);
            send_plain(len);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // rgb rows and bytes sent after the image is complete
    task automatic test_rgb_planes();
        configure(4'd2, MODE_RGB, 1'b0, 1'b0);
        send_image();
        send_plain(2);
    endtask

    // mask bits expanded to alpha at the smallest width, one row
    task automatic test_mask_bits();
        configure(4'd2, MODE_MASK, 1'b0, 1'b0);
        send_plain(row_bytes(2));
    endtask

    // alpha plane after the single mask byte, mip on at minimum width, one row
    task automatic test_alpha_plane();
        configure(4'd2, MODE_ALPHA, 1'b1, 1'b0);
        send_plain(row_bytes(2));
    endtask

    // size below range and channel modes outside the named ones
    task automatic test_odd_codes();
        configure(4'd0, 3'd0, 1'b0, 1'b0);
        send_plain(row_bytes(2));
        configure(4'd1, 3'd7, 1'b0, 1'b0);
        send_plain(14);
    endtask

    // size above range with all ten levels, then a huge length cut short by a restart
    task automatic test_compressed_levels();
        configure(4'd15, MODE_RGB, 1'b1, 1'b1);
        send_compressed(1, 1'b1);
        send_plain(1);
        configure(4'd2, MODE_RGB, 1'b0, 1'b1);
        repeat (4) send_word(8'hFF);
        send_plain(1);
    endtask

    // first colour bytes of a row at maximum width, left unfinished
    task automatic test_wide_row();
        configure(4'd11, MODE_MASK, 1'b0, 1'b0);
        send_plain(3);
    endtask

    task automatic test_random_streams();
        int         target;
        logic [3:0] size;
        logic [2:0] mode;
        bit         mip;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            calm = ($urandom_range(0, 3) == 0);
            mode = 3'($urandom_range(0, 7));
            mip  = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 2) == 0)
            begin
                // a single compressed level at any size code
                configure(4'($urandom_range(0, 15)), mode, 1'b0, 1'b1);
                send_compressed(6, 1'b0);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       size = 4'd0;
                    1:       size = 4'd1;
                    5:       size = 4'd3;
                    default: size = 4'd2;
                endcase
                configure(size, mode, mip, 1'b0);
                // the start of a stream, broken off by the next restart
                send_plain($urandom_range(1, 20));
            end
            if ($urandom_range(0, 3) == 0)
                send_plain($urandom_range(1, 4));
        end
        calm = 1'b0;
    endtask

    // closing stretch with no idling on either side: one row with a mask byte of 32 words
    task automatic test_back_to_back();
        calm = 1'b1;
        configure(4'd3, MODE_MASK, 1'b1, 1'b0);
        send_plain(row_bytes(3));
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_chan.valid     = 1'b0;
        in_chan.data_byte = '0;

        reg_size = 4'd2;
        reg_mode = MODE_RGB;
        reg_mip  = 1'b0;
        reg_comp = 1'b0;
        restart_stream();

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_rgb_planes();
        test_mask_bits();
        test_alpha_plane();
        test_odd_codes();
        test_compressed_levels();
        test_wide_row();
        test_random_streams();
        test_back_to_back();

        settle(TAIL_CYCLES);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ptrd_pkg.sv
rtl/ptrd_if.sv
rtl/ptrd_ram.sv
rtl/ptrd_ctrl.sv
rtl/ptrd_datapath.sv
rtl/planar_texture_row_deinterleaver_top.sv
rtl/ptrd_checker.sv
sim/testbench.sv
